@@ hdl/i2cbm_pkg.sv @@
// shared types and constants for the i2c bit-level master
// no dependencies; imported by the front queue, the bit engine and the top level
package i2cbm_pkg;

  localparam int unsigned BitsPerByte = 8;

  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_WAIT  = 3'd4;
  localparam logic [2:0] OP_READ  = 3'd5;

  localparam logic [1:0] CFG_SHORT_DELAY = 2'd0;
  localparam logic [1:0] CFG_LONG_DELAY  = 2'd1;
  localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd2;

  localparam logic [15:0] SHORT_DELAY_RST = 16'd2;
  localparam logic [15:0] LONG_DELAY_RST  = 16'd5;
  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;

  typedef struct packed {
    logic       cmd_ok;
    logic [2:0] opcode;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_in;
  } tick_t;

endpackage

@@ hdl/i2cbm_front.sv @@
// front side: takes tick beats, flags a runnable command and queues them
// depends on i2cbm_pkg
module i2cbm_front #(
  parameter int unsigned DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         opcode_i,
  input  logic [7:0]         write_data_i,
  input  logic               send_ack_i,
  input  logic               sda_in_i,
  output logic               head_valid_o,
  output i2cbm_pkg::tick_t   head_o,
  input  logic               pop_i
);
  import i2cbm_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  tick_t          mem_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  count_q, count_d;
  logic           full, empty, push, pop;
  tick_t          entry;

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);
  assign push  = in_valid_i & ~full;
  assign pop   = pop_i & ~empty;

  always_comb begin
    entry.opcode     = opcode_i;
    entry.write_data = write_data_i;
    entry.send_ack   = send_ack_i;
    entry.sda_in     = sda_in_i;
    entry.cmd_ok     = opcode_i inside {[OP_START:OP_READ]};
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

  assign in_stall_o   = full;
  assign head_valid_o = ~empty;
  assign head_o       = mem_q[rd_ptr_q];

endmodule

@@ hdl/i2cbm_engine.sv @@
// back side: bus bit sequencer, delay counter, config registers, result register
// depends on i2cbm_pkg
module i2cbm_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              head_valid_i,
  input  i2cbm_pkg::tick_t  head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              scl_level_o,
  output logic              sda_level_o,
  output logic              busy_res_o,
  output logic              done_res_o,
  output logic [7:0]        read_byte_o,
  output logic              ack_missing_o
);
  import i2cbm_pkg::*;

  localparam logic [4:0] PH_IDLE     = 5'd0;
  localparam logic [4:0] PH_ST_A     = 5'd1;
  localparam logic [4:0] PH_ST_B     = 5'd2;
  localparam logic [4:0] PH_ST_C     = 5'd3;
  localparam logic [4:0] PH_SP_A     = 5'd4;
  localparam logic [4:0] PH_SP_B     = 5'd5;
  localparam logic [4:0] PH_SP_C     = 5'd6;
  localparam logic [4:0] PH_WA_A     = 5'd7;
  localparam logic [4:0] PH_WA_B     = 5'd8;
  localparam logic [4:0] PH_WA_POLL  = 5'd9;
  localparam logic [4:0] PH_WR_A     = 5'd10;
  localparam logic [4:0] PH_WR_BIT   = 5'd11;
  localparam logic [4:0] PH_WR_LOW   = 5'd12;
  localparam logic [4:0] PH_WR_END   = 5'd13;
  localparam logic [4:0] PH_RD_A     = 5'd14;
  localparam logic [4:0] PH_RD_HI    = 5'd15;
  localparam logic [4:0] PH_RD_SMP   = 5'd16;
  localparam logic [4:0] PH_RD_ACK   = 5'd17;
  localparam logic [4:0] PH_RD_ACKHI = 5'd18;
  localparam logic [4:0] PH_RD_ACKLO = 5'd19;

  logic [15:0] short_q, long_q;
  logic [7:0]  timeout_q;

  logic [4:0]  phase_q, phase_d, ph;
  logic [3:0]  bits_q, bits_d, bits_inc;
  logic [15:0] delay_q, delay_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  poll_q, poll_d;
  logic        ack_q, ack_d;
  logic        scl_q, scl_d, sda_q, sda_d;
  logic [7:0]  result_q, result_d;
  logic        tmo_q, tmo_d;
  logic        done, run, idle, step;

  logic        out_valid_q;
  logic        o_scl_q, o_sda_q, o_busy_q, o_done_q, o_miss_q;
  logic [7:0]  o_byte_q;

  assign step  = head_valid_i & (~out_valid_q | ~out_stall_i);
  assign pop_o = step;
  assign idle  = (phase_q == PH_IDLE);
  assign bits_inc = bits_q + 1'b1;

  always_comb begin
    phase_d  = phase_q;
    bits_d   = bits_q;
    delay_d  = delay_q;
    shift_d  = shift_q;
    poll_d   = poll_q;
    ack_d    = ack_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    result_d = result_q;
    tmo_d    = tmo_q;
    done     = 1'b0;
    ph       = phase_q;
    run      = 1'b0;

    if (idle) begin
      if (head_i.cmd_ok) begin
        run     = 1'b1;
        delay_d = '0;
        case (head_i.opcode)
          OP_START: ph = PH_ST_A;
          OP_STOP:  ph = PH_SP_A;
          OP_WRITE: begin
            ph      = PH_WR_A;
            shift_d = head_i.write_data;
          end
          OP_WAIT:  ph = PH_WA_A;
          default: begin
            ph    = PH_RD_A;
            ack_d = head_i.send_ack;
          end
        endcase
      end
    end else if (delay_q != '0) begin
      delay_d = delay_q - 1'b1;
    end else begin
      run = 1'b1;
    end

    if (run) begin
      case (ph)
        PH_ST_A: begin
          scl_d = 1'b1; sda_d = 1'b1; delay_d = long_q; phase_d = PH_ST_B;
        end
        PH_ST_B: begin
          sda_d = 1'b0; delay_d = long_q; phase_d = PH_ST_C;
        end
        PH_ST_C: begin
          scl_d = 1'b0; phase_d = PH_IDLE; done = 1'b1;
        end
        PH_SP_A: begin
          scl_d = 1'b0; sda_d = 1'b0; delay_d = long_q; phase_d = PH_SP_B;
        end
        PH_SP_B: begin
          scl_d = 1'b1; sda_d = 1'b1; delay_d = long_q; phase_d = PH_SP_C;
        end
        PH_SP_C: begin
          phase_d = PH_IDLE; done = 1'b1;
        end
        PH_WA_A: begin
          sda_d = 1'b1; poll_d = '0; delay_d = long_q; phase_d = PH_WA_B;
        end
        PH_WA_B: begin
          scl_d = 1'b1; delay_d = long_q; phase_d = PH_WA_POLL;
        end
        PH_WA_POLL: begin
          if (!head_i.sda_in) begin
            scl_d = 1'b0; tmo_d = 1'b0; phase_d = PH_IDLE; done = 1'b1;
          end else if (poll_q >= timeout_q) begin
            tmo_d = 1'b1; phase_d = PH_SP_A;
          end else begin
            poll_d = poll_q + 1'b1;
          end
        end
        PH_WR_A: begin
          scl_d = 1'b0; bits_d = '0; phase_d = PH_WR_BIT;
        end
        PH_WR_BIT: begin
          scl_d   = 1'b1;
          sda_d   = shift_d[7];
          shift_d = {shift_d[6:0], 1'b0};
          delay_d = short_q;
          phase_d = PH_WR_LOW;
        end
        PH_WR_LOW: begin
          scl_d   = 1'b0;
          delay_d = short_q;
          bits_d  = bits_inc;
          phase_d = (bits_inc >= 4'(BitsPerByte)) ? PH_WR_END : PH_WR_BIT;
        end
        PH_WR_END: begin
          phase_d = PH_IDLE; done = 1'b1;
        end
        PH_RD_A: begin
          sda_d = 1'b1; bits_d = '0; shift_d = '0; phase_d = PH_RD_HI;
        end
        PH_RD_HI: begin
          scl_d = 1'b1; delay_d = short_q; phase_d = PH_RD_SMP;
        end
        PH_RD_SMP: begin
          shift_d = {shift_q[6:0], head_i.sda_in};
          scl_d   = 1'b0;
          delay_d = short_q;
          bits_d  = bits_inc;
          phase_d = (bits_inc >= 4'(BitsPerByte)) ? PH_RD_ACK : PH_RD_HI;
        end
        PH_RD_ACK: begin
          result_d = shift_q;
          scl_d    = 1'b0;
          sda_d    = ~ack_d;
          delay_d  = short_q;
          phase_d  = PH_RD_ACKHI;
        end
        PH_RD_ACKHI: begin
          scl_d = 1'b1; delay_d = long_q; phase_d = PH_RD_ACKLO;
        end
        PH_RD_ACKLO: begin
          scl_d = 1'b0; phase_d = PH_IDLE; done = 1'b1;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q   <= SHORT_DELAY_RST;
      long_q    <= LONG_DELAY_RST;
      timeout_q <= ACK_TIMEOUT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SHORT_DELAY: short_q   <= cfg_data_i;
        CFG_LONG_DELAY:  long_q    <= cfg_data_i;
        CFG_ACK_TIMEOUT: timeout_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bits_q      <= '0;
      delay_q     <= '0;
      shift_q     <= '0;
      poll_q      <= '0;
      ack_q       <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      result_q    <= '0;
      tmo_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        phase_q  <= phase_d;
        bits_q   <= bits_d;
        delay_q  <= delay_d;
        shift_q  <= shift_d;
        poll_q   <= poll_d;
        ack_q    <= ack_d;
        scl_q    <= scl_d;
        sda_q    <= sda_d;
        result_q <= result_d;
        tmo_q    <= tmo_d;
      end
      out_valid_q <= step | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      o_scl_q  <= scl_d;
      o_sda_q  <= sda_d;
      o_busy_q <= (phase_d != PH_IDLE);
      o_done_q <= done;
      o_byte_q <= result_d;
      o_miss_q <= tmo_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign scl_level_o   = o_scl_q;
  assign sda_level_o   = o_sda_q;
  assign busy_res_o    = o_busy_q;
  assign done_res_o    = o_done_q;
  assign read_byte_o   = o_byte_q;
  assign ack_missing_o = o_miss_q;

endmodule

@@ hdl/i2c_bit_level_master.sv @@
// top level of the tick-driven i2c bit-level master: tick queue plus bit engine
// depends on i2cbm_pkg, i2cbm_front, i2cbm_engine
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid_i/in_stall_o | opcode, write_data, send_ack, sda_in
//  out     | output    | out_valid_o/out_stall_i | scl/sda level, busy, done, read byte, ack
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one result beat per tick beat, one tick per clock when neither side stalls
// a tick is first written into the queue register; the engine then runs it into the output register
// the engine advances only when the output register is free or being drained
// reset puts both line registers high, the engine idle, delays at 2 and 5, ack timeout at 250
// input stall rises only when the tick queue is full
module i2c_bit_level_master #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [7:0]  write_data_i,
  input  logic        send_ack_i,
  input  logic        sda_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        scl_level_o,
  output logic        sda_level_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [7:0]  read_byte_o,
  output logic        ack_missing_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import i2cbm_pkg::*;

  tick_t head;
  logic  head_valid, pop;

  assign cfg_ready_o = 1'b1;

  i2cbm_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .write_data_i(write_data_i),
    .send_ack_i  (send_ack_i),
    .sda_in_i    (sda_in_i),
    .head_valid_o(head_valid),
    .head_o      (head),
    .pop_i       (pop)
  );

  i2cbm_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i & cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .scl_level_o  (scl_level_o),
    .sda_level_o  (sda_level_o),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o),
    .read_byte_o  (read_byte_o),
    .ack_missing_o(ack_missing_o)
  );

endmodule

@@ dv/tb_i2c_bit_level_master.sv @@
`timescale 1ns / 100ps
// testbench for i2c_bit_level_master: directed and random command ticks from a bursty source,
// patterned output stall, each result beat checked against an in-bench model of the bit engine
// depends on i2cbm_pkg and the i2c_bit_level_master rtl
module tb_i2c_bit_level_master;
  import i2cbm_pkg::*;

  localparam logic [2:0] OP_RSVD_6 = 3'd6;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C, PH_SP_A, PH_SP_B, PH_SP_C,
    PH_WA_A, PH_WA_B, PH_WA_POLL, PH_WR_A, PH_WR_BIT, PH_WR_LOW, PH_WR_END,
    PH_RD_A, PH_RD_HI, PH_RD_SMP, PH_RD_ACK, PH_RD_ACKHI, PH_RD_ACKLO
  } eng_phase_e;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_e;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] wdata;
    logic       send_ack;
    logic       sda;
  } bus_tick_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rbyte;
    logic       ack_missing;
  } line_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  opcode_i = OP_NONE;
  logic [7:0]  write_data_i = 8'h00;
  logic        send_ack_i = 1'b0;
  logic        sda_in_i = 1'b1;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        scl_level_o;
  logic        sda_level_o;
  logic        busy_res_o;
  logic        done_res_o;
  logic [7:0]  read_byte_o;
  logic        ack_missing_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CFG_SHORT_DELAY;
  logic [15:0] cfg_data_i = 16'h0000;

  // model of the engine and its delay registers
  logic [15:0] short_ticks;
  logic [15:0] long_ticks;
  logic [7:0]  ack_limit;
  eng_phase_e  eng_phase;
  logic [2:0]  eng_cmd;
  logic [3:0]  eng_bits;
  logic [15:0] eng_delay;
  logic [7:0]  eng_shift;
  logic [7:0]  eng_polls;
  logic        eng_ack_sel;
  logic        eng_scl;
  logic        eng_sda;
  logic [7:0]  eng_rbyte;
  logic        eng_tmo;

  bus_tick_t   tick_q[$];
  line_res_t   line_exp_q[$];
  bus_tick_t   head_tick;
  line_res_t   want_res;

  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_age = 0;
  stall_mode_e stall_mode = STALL_NONE;

  i2c_bit_level_master uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .write_data_i  (write_data_i),
    .send_ack_i    (send_ack_i),
    .sda_in_i      (sda_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .scl_level_o   (scl_level_o),
    .sda_level_o   (sda_level_o),
    .busy_res_o    (busy_res_o),
    .done_res_o    (done_res_o),
    .read_byte_o   (read_byte_o),
    .ack_missing_o (ack_missing_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic run_phase(input logic sda);
    logic fin;
    fin = 1'b0;
    case (eng_phase)
      PH_ST_A: begin
        eng_scl = 1'b1; eng_sda = 1'b1; eng_delay = long_ticks; eng_phase = PH_ST_B;
      end
      PH_ST_B: begin
        eng_sda = 1'b0; eng_delay = long_ticks; eng_phase = PH_ST_C;
      end
      PH_ST_C: begin
        eng_scl = 1'b0; eng_phase = PH_IDLE; fin = 1'b1;
      end
      PH_SP_A: begin
        eng_scl = 1'b0; eng_sda = 1'b0; eng_delay = long_ticks; eng_phase = PH_SP_B;
      end
      PH_SP_B: begin
        eng_scl = 1'b1; eng_sda = 1'b1; eng_delay = long_ticks; eng_phase = PH_SP_C;
      end
      PH_SP_C: begin
        eng_phase = PH_IDLE; fin = 1'b1;
      end
      PH_WA_A: begin
        eng_sda = 1'b1; eng_polls = 8'd0; eng_delay = long_ticks; eng_phase = PH_WA_B;
      end
      PH_WA_B: begin
        eng_scl = 1'b1; eng_delay = long_ticks; eng_phase = PH_WA_POLL;
      end
      PH_WA_POLL: begin
        if (!sda) begin
          eng_scl = 1'b0; eng_tmo = 1'b0; eng_phase = PH_IDLE; fin = 1'b1;
        end else if (eng_polls >= ack_limit) begin
          eng_tmo = 1'b1; eng_phase = PH_SP_A;
        end else begin
          eng_polls = eng_polls + 8'd1;
        end
      end
      PH_WR_A: begin
        eng_scl = 1'b0; eng_bits = 4'd0; eng_phase = PH_WR_BIT;
      end
      PH_WR_BIT: begin
        eng_scl = 1'b1; eng_sda = eng_shift[7]; eng_shift = eng_shift << 1;
        eng_delay = short_ticks; eng_phase = PH_WR_LOW;
      end
      PH_WR_LOW: begin
        eng_scl = 1'b0; eng_delay = short_ticks; eng_bits = eng_bits + 4'd1;
        eng_phase = (eng_bits >= BitsPerByte) ? PH_WR_END : PH_WR_BIT;
      end
      PH_WR_END: begin
        eng_phase = PH_IDLE; fin = 1'b1;
      end
      PH_RD_A: begin
        eng_sda = 1'b1; eng_bits = 4'd0; eng_shift = 8'd0; eng_phase = PH_RD_HI;
      end
      PH_RD_HI: begin
        eng_scl = 1'b1; eng_delay = short_ticks; eng_phase = PH_RD_SMP;
      end
      PH_RD_SMP: begin
        eng_shift = {eng_shift[6:0], sda}; eng_scl = 1'b0; eng_delay = short_ticks;
        eng_bits = eng_bits + 4'd1;
        eng_phase = (eng_bits >= BitsPerByte) ? PH_RD_ACK : PH_RD_HI;
      end
      PH_RD_ACK: begin
        eng_rbyte = eng_shift; eng_scl = 1'b0; eng_sda = !eng_ack_sel;
        eng_delay = short_ticks; eng_phase = PH_RD_ACKHI;
      end
      PH_RD_ACKHI: begin
        eng_scl = 1'b1; eng_delay = long_ticks; eng_phase = PH_RD_ACKLO;
      end
      PH_RD_ACKLO: begin
        eng_scl = 1'b0; eng_phase = PH_IDLE; fin = 1'b1;
      end
      default: eng_phase = PH_IDLE;
    endcase
    return fin;
  endfunction

  function automatic line_res_t engine_tick(input bus_tick_t tk);
    line_res_t r;
    logic fin;
    fin = 1'b0;
    if (eng_phase == PH_IDLE) begin
      if (tk.opcode >= OP_START && tk.opcode <= OP_READ) begin
        eng_cmd = tk.opcode;
        eng_delay = 16'd0;
        case (tk.opcode)
          OP_START: eng_phase = PH_ST_A;
          OP_STOP:  eng_phase = PH_SP_A;
          OP_WRITE: begin
            eng_phase = PH_WR_A; eng_shift = tk.wdata;
          end
          OP_WAIT:  eng_phase = PH_WA_A;
          default: begin
            eng_phase = PH_RD_A; eng_ack_sel = tk.send_ack;
          end
        endcase
        fin = run_phase(tk.sda);
      end
    end else if (eng_delay != 16'd0) begin
      eng_delay = eng_delay - 16'd1;
    end else begin
      fin = run_phase(tk.sda);
    end
    r.scl = eng_scl;
    r.sda = eng_sda;
    r.busy = (eng_phase != PH_IDLE);
    r.done = fin;
    r.rbyte = eng_rbyte;
    r.ack_missing = eng_tmo;
    return r;
  endfunction

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  function automatic int rand_slack();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return 0;
    if (roll < 8) return $urandom_range(1, 4);
    return -int'($urandom_range(1, 8));
  endfunction

  function automatic int pick_polls();
    if ($urandom_range(0, 3) == 0) return int'(ack_limit) + 1 + $urandom_range(0, 3);
    return $urandom_range(0, ack_limit);
  endfunction

  // queues one command tick and the idle ticks that its run takes, plus slack
  task automatic push_cmd(input logic [2:0] op, input logic [7:0] data, input logic sack,
                          input int high_polls, input int slack);
    bus_tick_t tk;
    int s;
    int l;
    int t;
    int poll0;
    int span;
    int n;
    int k;
    s = int'(short_ticks);
    l = int'(long_ticks);
    t = int'(ack_limit);
    poll0 = 2 * l + 3;
    case (op)
      OP_START, OP_STOP: span = 2 * l + 3;
      OP_WRITE: span = 18 + 16 * s;
      OP_READ:  span = 20 + 17 * s + l;
      OP_WAIT:  span = (high_polls > t) ? 4 * l + 6 + t : poll0 + high_polls;
      default:  span = 1;
    endcase
    n = span + slack;
    if (n < 1) n = 1;
    for (k = 1; k <= n; k++) begin
      tk.opcode = (k == 1) ? op : OP_NONE;
      tk.wdata = (k == 1) ? data : 8'($urandom);
      tk.send_ack = (k == 1) ? sack : 1'($urandom);
      if (op == OP_WAIT && k >= poll0 && k < poll0 + high_polls) tk.sda = 1'b1;
      else if (op == OP_WAIT && k == poll0 + high_polls) tk.sda = 1'b0;
      else tk.sda = 1'($urandom);
      tick_q.push_back(tk);
    end
  endtask

  task automatic push_transfer();
    int n_data;
    n_data = $urandom_range(1, 3);
    push_cmd(OP_START, 8'($urandom), 1'($urandom), 0, rand_slack());
    push_cmd(OP_WRITE, 8'($urandom), 1'($urandom), 0, rand_slack());
    push_cmd(OP_WAIT, 8'($urandom), 1'($urandom), pick_polls(), rand_slack());
    repeat (n_data) begin
      if ($urandom_range(0, 1) == 0) begin
        push_cmd(OP_WRITE, 8'($urandom), 1'($urandom), 0, rand_slack());
        push_cmd(OP_WAIT, 8'($urandom), 1'($urandom), pick_polls(), rand_slack());
      end else begin
        push_cmd(OP_READ, 8'($urandom), 1'($urandom), 0, rand_slack());
      end
    end
    push_cmd(OP_STOP, 8'($urandom), 1'($urandom), 0, rand_slack());
  endtask

  task automatic drain();
    while (tick_q.size() != 0 || in_valid_i || line_exp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // let the engine run out so that no hold or command spans a register write
  task automatic finish_phase();
    drain();
    while (eng_phase != PH_IDLE) begin
      push_cmd(OP_NONE, 8'h00, 1'b0, 0, int'(eng_delay) + 7);
      drain();
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_SHORT_DELAY: short_ticks = val;
      CFG_LONG_DELAY:  long_ticks = val;
      default:         ack_limit = val[7:0];
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_timing(input logic [15:0] s, input logic [15:0] l, input logic [7:0] t);
    write_reg(CFG_SHORT_DELAY, s);
    write_reg(CFG_LONG_DELAY, l);
    write_reg(CFG_ACK_TIMEOUT, {8'h00, t});
  endtask

  initial begin
    short_ticks = SHORT_DELAY_RST;
    long_ticks = LONG_DELAY_RST;
    ack_limit = ACK_TIMEOUT_RST;
    eng_phase = PH_IDLE;
    eng_cmd = OP_NONE;
    eng_bits = 4'd0;
    eng_delay = 16'd0;
    eng_shift = 8'd0;
    eng_polls = 8'd0;
    eng_ack_sel = 1'b0;
    eng_scl = 1'b1;
    eng_sda = 1'b1;
    eng_rbyte = 8'd0;
    eng_tmo = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset timing
    push_cmd(OP_RSVD_6, 8'hFF, 1'b1, 0, 0);
    push_cmd(OP_RSVD_7, 8'h00, 1'b0, 0, 0);
    push_cmd(OP_NONE, 8'h5A, 1'b1, 0, 2);
    push_cmd(OP_START, 8'h00, 1'b0, 0, 0);
    push_cmd(OP_WRITE, 8'hFF, 1'b0, 0, 0);
    push_cmd(OP_WRITE, 8'h00, 1'b1, 0, 0);
    push_cmd(OP_WRITE, 8'hA5, 1'b0, 0, 1);
    push_cmd(OP_WAIT, 8'h00, 1'b0, 0, 0);
    push_cmd(OP_WAIT, 8'h00, 1'b0, 3, 0);
    push_cmd(OP_READ, 8'h00, 1'b1, 0, 0);
    push_cmd(OP_READ, 8'hFF, 1'b0, 0, 0);
    // command arriving while busy is dropped
    push_cmd(OP_START, 8'h00, 1'b0, 0, -3);
    push_cmd(OP_WRITE, 8'h3C, 1'b0, 0, 0);
    // ack never comes: timeout then automatic stop
    push_cmd(OP_WAIT, 8'h00, 1'b0, int'(ack_limit) + 1, 0);
    push_cmd(OP_STOP, 8'h00, 1'b0, 0, 0);
    finish_phase();

    // zero holds, timeout on the first high poll
    set_timing(16'd0, 16'd0, 8'd0);
    push_cmd(OP_START, 8'h00, 1'b0, 0, 0);
    push_cmd(OP_WRITE, 8'hC3, 1'b0, 0, 0);
    push_cmd(OP_WAIT, 8'h00, 1'b0, 1, 0);
    push_cmd(OP_READ, 8'h00, 1'b1, 0, 0);
    push_cmd(OP_WAIT, 8'h00, 1'b0, 0, 0);
    push_cmd(OP_STOP, 8'h00, 1'b0, 0, 0);
    finish_phase();

    set_timing(16'hFFFF, 16'd1, 8'hFF);
    push_cmd(OP_START, 8'h00, 1'b0, 0, 0);
    push_cmd(OP_WAIT, 8'h00, 1'b0, 256, 0);
    finish_phase();

    set_timing(16'd1, 16'd20, 8'd1);
    push_cmd(OP_STOP, 8'h00, 1'b0, 0, 0);
    finish_phase();

    // random transfers with some stray and overlapping commands
    repeat (2) begin
      set_timing(16'($urandom_range(0, 3)), 16'($urandom_range(0, 6)),
                 8'($urandom_range(0, 12)));
      while (tick_q.size() < 60) begin
        if ($urandom_range(0, 4) == 0) begin
          push_cmd(3'($urandom), 8'($urandom), 1'($urandom), pick_polls(), rand_slack());
        end else begin
          push_transfer();
        end
      end
      finish_phase();
    end

    if (mismatches == 0) begin
      $display("i2c_bit_level_master test passed");
    end else begin
      $display("i2c_bit_level_master test failed");
    end
    $finish;
  end

  // source: bursts of beats with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        line_exp_q.push_back(engine_tick({opcode_i, write_data_i, send_ack_i, sda_in_i}));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (tick_q.size() != 0) begin
          head_tick = tick_q.pop_front();
          in_valid_i <= 1'b1;
          opcode_i <= head_tick.opcode;
          write_data_i <= head_tick.wdata;
          send_ack_i <= head_tick.send_ack;
          sda_in_i <= head_tick.sda;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 32);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // sink stall pattern, in a mode drawn at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_age <= 0;
      stall_mode <= STALL_NONE;
    end else begin
      stall_age <= stall_age + 1;
      if (stall_age % 96 == 0) stall_mode <= stall_mode_e'($urandom_range(0, 3));
      case (stall_mode)
        STALL_NONE:     out_stall_i <= 1'b0;
        STALL_LIGHT:    out_stall_i <= ($urandom_range(0, 9) < 3);
        STALL_PERIODIC: out_stall_i <= (stall_age % 4 == 1);
        default:        out_stall_i <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (line_exp_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual scl %b sda %b busy %b done %b",
                 $time, scl_level_o, sda_level_o, busy_res_o, done_res_o);
        mismatches++;
      end else begin
        want_res = line_exp_q.pop_front();
        check_field("scl_level", 32'(want_res.scl), 32'(scl_level_o));
        check_field("sda_level", 32'(want_res.sda), 32'(sda_level_o));
        check_field("busy_res", 32'(want_res.busy), 32'(busy_res_o));
        check_field("done_res", 32'(want_res.done), 32'(done_res_o));
        check_field("read_byte", 32'(want_res.rbyte), 32'(read_byte_o));
        check_field("ack_missing", 32'(want_res.ack_missing), 32'(ack_missing_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("i2c_bit_level_master test failed");
      $finish;
    end
  end

endmodule
